// ===== hdl/rsu_pkg.sv =====
package rsu_pkg;

    // lattice geometry
    localparam int SIDE_DEF = 64;
    localparam int ROW_W    = 6;

    // field widths
    localparam int JW      = 13;
    localparam int RGW     = 7;
    localparam int THR_W   = 17;
    localparam int EW      = 40;
    localparam int DE_W    = 18;
    localparam int SPIN_W  = 2;
    localparam int ACOEF_W = 3;
    localparam int COEF_W  = 6;

    // apb port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // register reset values, Q.8
    localparam logic signed [JW-1:0] J_RESET      = 13'sd256;
    localparam logic signed [JW-1:0] D_RESET      = 13'sd486;
    localparam logic [RGW-1:0]       REGION_RESET = '0;

    typedef enum logic [1:0] {
        CMD_UPDATE      = 2'd0,
        CMD_LOAD_SITE   = 2'd1,
        CMD_LOAD_ENERGY = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_PREP,
        ST_MUL_D,
        ST_MUL_J,
        ST_COMMIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [JW-1:0] coupling_j;
        logic signed [JW-1:0] anisotropy_d;
        logic [RGW-1:0]       region_rows;
    } cfg_t;

    typedef struct packed {
        logic en;
        logic clear;
    } mac_ctl_t;

endpackage

// ===== hdl/rsu_if.sv =====
interface rsu_req_if;
    import rsu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic                     layer;
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic                     choice;
    logic [THR_W-1:0]         threshold;
    logic signed [SPIN_W-1:0] spin_value;
    logic signed [EW-1:0]     energy_value;

    modport source (
        output valid, command, layer, row, col, choice, threshold, spin_value,
               energy_value,
        input  ready
    );

    modport sink (
        input  valid, command, layer, row, col, choice, threshold, spin_value,
               energy_value,
        output ready
    );
endinterface

interface rsu_rsp_if;
    import rsu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [SPIN_W-1:0] old_spin;
    logic signed [SPIN_W-1:0] site_spin;
    logic signed [DE_W-1:0]   energy_change;
    logic signed [EW-1:0]     energy_total;

    modport source (
        output valid, accepted, old_spin, site_spin, energy_change, energy_total,
        input  ready
    );

    modport sink (
        input  valid, accepted, old_spin, site_spin, energy_change, energy_total,
        output ready
    );
endinterface

// ===== hdl/rsu_ram.sv =====
module rsu_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/rsu_mac.sv =====
module rsu_mac (
    input  logic                                 clk,
    input  rsu_pkg::mac_ctl_t                    ctl,
    input  logic signed [rsu_pkg::JW-1:0]        a,
    input  logic signed [rsu_pkg::COEF_W-1:0]    b,
    output logic signed [rsu_pkg::DE_W-1:0]      acc
);
    import rsu_pkg::*;

    localparam int PW = JW + COEF_W;

    logic signed [PW-1:0] prod;
    logic [DE_W-1:0]      base;
    logic [DE_W-1:0]      acc_reg;
    logic [DE_W-1:0]      acc_next;

    // 13 x 6 signed product, truncated to the accumulator width
    always_comb
    begin
        prod     = PW'(a) * PW'(b);
        base     = ctl.clear ? '0 : acc_reg;
        acc_next = base + prod[DE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = $signed(acc_reg);
endmodule

// ===== hdl/rsu_cfg.sv =====
module rsu_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsu_pkg::APB_AW-1:0]  paddr,
    input  logic [rsu_pkg::APB_DW-1:0]  pwdata,
    output logic [rsu_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output rsu_pkg::cfg_t               cfg
);
    import rsu_pkg::*;

    localparam logic [1:0] REG_COUPLING = 2'd0;
    localparam logic [1:0] REG_ANISO    = 2'd1;
    localparam logic [1:0] REG_REGION   = 2'd2;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_COUPLING: cfg_next.coupling_j   = $signed(pwdata[JW-1:0]);
                REG_ANISO:    cfg_next.anisotropy_d = $signed(pwdata[JW-1:0]);
                REG_REGION:   cfg_next.region_rows  = pwdata[RGW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COUPLING: prdata = APB_DW'(cfg_reg.coupling_j);
            REG_ANISO:    prdata = APB_DW'(cfg_reg.anisotropy_d);
            REG_REGION:   prdata = APB_DW'(cfg_reg.region_rows);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coupling_j   <= J_RESET;
            cfg_reg.anisotropy_d <= D_RESET;
            cfg_reg.region_rows  <= REGION_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== hdl/metropolis_spin1_replica_update_unit.sv =====
// sequence: for every command, ST_READ issues the five registered reads of the site and
//   its neighbours on the one read port of each lattice memory, then ST_LAST, ST_PREP,
//   two passes through the shared multiply-add unit (ST_MUL_D, ST_MUL_J), ST_COMMIT and
//   ST_DONE with response.valid; a new item is taken in ST_IDLE after response.ready
// reset: rst_n is asynchronous, active low; it clears the sequencer and the energy
//   total and restores the register defaults; lattice contents are not cleared
module metropolis_spin1_replica_update_unit #(
    parameter int SIDE = rsu_pkg::SIDE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rsu_req_if.sink                     request,
    rsu_rsp_if.source                   response,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsu_pkg::APB_AW-1:0]  paddr,
    input  logic [rsu_pkg::APB_DW-1:0]  pwdata,
    output logic [rsu_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import rsu_pkg::*;

    // lattice addressing: {row, col}, each index as wide as SIDE needs
    localparam int RW     = (SIDE > 1) ? $clog2(SIDE) : 1;
    localparam int AW     = 2 * RW;
    localparam int DEPTH  = 1 << AW;
    localparam int IW     = (RW > ROW_W) ? RW : ROW_W;
    localparam int CMP_W  = ((RW > RGW) ? RW : RGW) + 1;
    localparam logic [RW-1:0] LAST_IDX = RW'(SIDE - 1);
    localparam logic [IW:0]   SIDE_X   = (IW + 1)'(SIDE);

    // read sequence: site first, then the four neighbours
    localparam logic [2:0] NB_CENTER = 3'd0;
    localparam logic [2:0] NB_UP     = 3'd1;
    localparam logic [2:0] NB_DOWN   = 3'd2;
    localparam logic [2:0] NB_LEFT   = 3'd3;
    localparam logic [2:0] NB_RIGHT  = 3'd4;

    cfg_t cfg;

    state_t state_reg;
    state_t state_next;

    // latched item
    logic [1:0]               cmd_reg,    cmd_next;
    logic                     layer_reg,  layer_next;
    logic [RW-1:0]            row_reg,    row_next;
    logic [RW-1:0]            col_reg,    col_next;
    logic                     choice_reg, choice_next;
    logic [THR_W-1:0]         thr_reg,    thr_next;
    logic [SPIN_W-1:0]        sv_reg,     sv_next;
    logic [EW-1:0]            ev_reg,     ev_next;
    logic                     shared_reg, shared_next;

    // read sequencer and capture pipe
    logic [2:0]               rd_idx_reg,  rd_idx_next;
    logic                     cap_en_reg,  cap_en_next;
    logic [2:0]               cap_idx_reg, cap_idx_next;
    logic                     cap_ok_reg,  cap_ok_next;

    // gathered lattice values
    logic signed [SPIN_W-1:0] old_a_reg, old_a_next;
    logic signed [SPIN_W-1:0] old_b_reg, old_b_next;
    logic signed [3:0]        sum_a_reg, sum_a_next;
    logic signed [3:0]        sum_b_reg, sum_b_next;

    // proposal and multiplier coefficients
    logic signed [SPIN_W-1:0]  new_reg,   new_next;
    logic signed [ACOEF_W-1:0] acoef_reg, acoef_next;
    logic signed [COEF_W-1:0]  ccoef_reg, ccoef_next;

    // result
    logic                     accepted_reg, accepted_next;
    logic [SPIN_W-1:0]        old_out_reg,  old_out_next;
    logic [SPIN_W-1:0]        site_out_reg, site_out_next;
    logic [DE_W-1:0]          de_out_reg,   de_out_next;
    logic [EW-1:0]            total_reg,    total_next;

    // request field conditioning
    logic [IW:0]              row_x;
    logic [IW:0]              col_x;
    logic [RW-1:0]            row_c;
    logic [RW-1:0]            col_c;
    logic                     shared_c;
    logic [SPIN_W-1:0]        sv_c;

    // memory side
    logic [RW-1:0]            nb_row;
    logic [RW-1:0]            nb_col;
    logic                     nb_ok;
    logic [AW-1:0]            nb_addr;
    logic [AW-1:0]            pos;
    logic [SPIN_W-1:0]        rdata_one;
    logic [SPIN_W-1:0]        rdata_two;
    logic signed [SPIN_W-1:0] rd_a;
    logic signed [SPIN_W-1:0] rd_b;
    logic                     we_a;
    logic                     we_b;
    logic                     we_one;
    logic                     we_two;
    logic [SPIN_W-1:0]        wdata;

    // proposal math
    logic signed [SPIN_W-1:0]  new_c;
    logic                      sq_new;
    logic                      sq_old;
    logic signed [ACOEF_W-1:0] dsq;
    logic signed [2:0]         diff_a;
    logic signed [2:0]         diff_b;
    logic signed [6:0]         prod_a;
    logic signed [6:0]         prod_b;
    logic signed [6:0]         coup_sum;

    // shared multiply-add unit
    mac_ctl_t                  mac_ctl;
    logic signed [JW-1:0]      mac_a;
    logic signed [COEF_W-1:0]  mac_b;
    logic signed [DE_W-1:0]    de;
    logic                      keep;

    logic                      accept_item;

    rsu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsu_ram #(
        .WIDTH (SPIN_W),
        .DEPTH (DEPTH)
    ) mem_one (
        .clk   (clk),
        .we    (we_one),
        .waddr (pos),
        .wdata (wdata),
        .raddr (nb_addr),
        .rdata (rdata_one)
    );

    rsu_ram #(
        .WIDTH (SPIN_W),
        .DEPTH (DEPTH)
    ) mem_two (
        .clk   (clk),
        .we    (we_two),
        .waddr (pos),
        .wdata (wdata),
        .raddr (nb_addr),
        .rdata (rdata_two)
    );

    rsu_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mac_a),
        .b   (mac_b),
        .acc (de)
    );

    // clamp indices past the lattice edge to the last row or column
    assign row_x    = (IW + 1)'(request.row);
    assign col_x    = (IW + 1)'(request.col);
    assign row_c    = (row_x >= SIDE_X) ? LAST_IDX : row_x[RW-1:0];
    assign col_c    = (col_x >= SIDE_X) ? LAST_IDX : col_x[RW-1:0];
    assign shared_c = CMP_W'(row_c) < CMP_W'(cfg.region_rows);
    // the unused pattern -2 saturates to -1
    assign sv_c     = (request.spin_value == 2'b10) ? 2'b11 : request.spin_value;

    assign accept_item = request.valid && request.ready;

    // neighbour address for the current read slot; off-lattice slots are masked
    always_comb
    begin
        nb_row = row_reg;
        nb_col = col_reg;
        nb_ok  = 1'b1;
        case (rd_idx_reg)
            NB_UP:
            begin
                nb_row = row_reg - 1'b1;
                nb_ok  = (row_reg != '0);
            end
            NB_DOWN:
            begin
                nb_row = row_reg + 1'b1;
                nb_ok  = (row_reg != LAST_IDX);
            end
            NB_LEFT:
            begin
                nb_col = col_reg - 1'b1;
                nb_ok  = (col_reg != '0);
            end
            NB_RIGHT:
            begin
                nb_col = col_reg + 1'b1;
                nb_ok  = (col_reg != LAST_IDX);
            end
            default: ;
        endcase
    end

    assign nb_addr = {nb_row, nb_col};
    assign pos     = {row_reg, col_reg};

    // chosen layer is "a", the other one is "b"
    assign rd_a = layer_reg ? rdata_two : rdata_one;
    assign rd_b = layer_reg ? rdata_one : rdata_two;

    // proposal: the two other spin values in ascending order
    always_comb
    begin
        case (old_a_reg)
            2'sd0:   new_c = choice_reg ? 2'sd1 : -2'sd1;
            2'sd1:   new_c = choice_reg ? 2'sd0 : -2'sd1;
            default: new_c = choice_reg ? 2'sd1 : 2'sd0;
        endcase
        sq_new   = (new_c != '0);
        sq_old   = (old_a_reg != '0);
        dsq      = $signed({2'b00, sq_new}) - $signed({2'b00, sq_old});
        diff_a   = 3'(new_c) - 3'(old_a_reg);
        diff_b   = 3'(new_c) - 3'(old_b_reg);
        prod_a   = 7'(diff_a) * 7'(sum_a_reg);
        prod_b   = shared_reg ? 7'(diff_b) * 7'(sum_b_reg) : 7'sd0;
        coup_sum = prod_a + prod_b;
    end

    // move is kept when the change is at most the threshold
    assign keep = (cmd_reg == CMD_UPDATE) &&
                  ($signed({de[DE_W-1], de}) <= $signed({2'b00, thr_reg}));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (request.valid) state_next = ST_READ;
            ST_READ:   if (rd_idx_reg == NB_RIGHT) state_next = ST_LAST;
            ST_LAST:   state_next = ST_PREP;
            ST_PREP:   state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_J;
            ST_MUL_J:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_DONE;
            ST_DONE:   if (response.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        request.ready  = 1'b0;
        response.valid = 1'b0;
        mac_ctl        = '0;
        mac_a          = cfg.anisotropy_d;
        mac_b          = COEF_W'(acoef_reg);
        we_a           = 1'b0;
        we_b           = 1'b0;
        unique case (state_reg)
            ST_IDLE:   request.ready = 1'b1;
            ST_MUL_D:
            begin
                // D * (new^2 - old^2), doubled for a shared row
                mac_ctl.en    = 1'b1;
                mac_ctl.clear = 1'b1;
            end
            ST_MUL_J:
            begin
                // add -J * sum of (new - old) * neighbour sum
                mac_ctl.en = 1'b1;
                mac_a      = cfg.coupling_j;
                mac_b      = ccoef_reg;
            end
            ST_COMMIT:
            begin
                we_a = (cmd_reg == CMD_UPDATE) || (cmd_reg == CMD_LOAD_SITE);
                we_b = (cmd_reg == CMD_UPDATE) && shared_reg;
            end
            ST_DONE:   response.valid = 1'b1;
            default: ;
        endcase
    end

    assign we_one = layer_reg ? we_b : we_a;
    assign we_two = layer_reg ? we_a : we_b;
    // a rejected move writes the old spin back, which on a shared row also aligns the other layer
    assign wdata  = (cmd_reg == CMD_LOAD_SITE) ? sv_reg : (keep ? new_reg : old_a_reg);

    // datapath next values
    always_comb
    begin
        cmd_next      = cmd_reg;
        layer_next    = layer_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        choice_next   = choice_reg;
        thr_next      = thr_reg;
        sv_next       = sv_reg;
        ev_next       = ev_reg;
        shared_next   = shared_reg;
        rd_idx_next   = rd_idx_reg;
        cap_idx_next  = rd_idx_reg;
        cap_ok_next   = nb_ok;
        cap_en_next   = (state_reg == ST_READ);
        old_a_next    = old_a_reg;
        old_b_next    = old_b_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        new_next      = new_reg;
        acoef_next    = acoef_reg;
        ccoef_next    = ccoef_reg;
        accepted_next = accepted_reg;
        old_out_next  = old_out_reg;
        site_out_next = site_out_reg;
        de_out_next   = de_out_reg;
        total_next    = total_reg;

        if (accept_item)
        begin
            cmd_next    = request.command;
            layer_next  = request.layer;
            row_next    = row_c;
            col_next    = col_c;
            choice_next = request.choice;
            thr_next    = request.threshold;
            sv_next     = sv_c;
            ev_next     = request.energy_value;
            shared_next = shared_c;
            rd_idx_next = NB_CENTER;
            sum_a_next  = '0;
            sum_b_next  = '0;
        end

        if (state_reg == ST_READ)
        begin
            rd_idx_next = rd_idx_reg + 3'd1;
        end

        // read data is registered in the memory and lands in the cycle after its address
        if (cap_en_reg)
        begin
            if (cap_idx_reg == NB_CENTER)
            begin
                old_a_next = rd_a;
                old_b_next = rd_b;
            end
            else if (cap_ok_reg)
            begin
                sum_a_next = sum_a_reg + 4'(rd_a);
                sum_b_next = sum_b_reg + 4'(rd_b);
            end
        end

        if (state_reg == ST_PREP)
        begin
            new_next   = new_c;
            acoef_next = shared_reg ? (dsq <<< 1) : dsq;
            ccoef_next = COEF_W'(-coup_sum);
        end

        if (state_reg == ST_COMMIT)
        begin
            accepted_next = 1'b0;
            old_out_next  = '0;
            site_out_next = '0;
            de_out_next   = '0;
            unique case (cmd_reg)
                CMD_UPDATE:
                begin
                    accepted_next = keep;
                    old_out_next  = old_a_reg;
                    site_out_next = keep ? new_reg : old_a_reg;
                    de_out_next   = de;
                    if (keep)
                    begin
                        total_next = total_reg + {{(EW - DE_W){de[DE_W-1]}}, de};
                    end
                end
                CMD_LOAD_SITE:
                begin
                    old_out_next  = old_a_reg;
                    site_out_next = sv_reg;
                end
                CMD_LOAD_ENERGY: total_next = ev_reg;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_idx_reg <= NB_CENTER;
            cap_en_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            cap_en_reg <= cap_en_next;
            total_reg  <= total_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        layer_reg    <= layer_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        choice_reg   <= choice_next;
        thr_reg      <= thr_next;
        sv_reg       <= sv_next;
        ev_reg       <= ev_next;
        shared_reg   <= shared_next;
        cap_idx_reg  <= cap_idx_next;
        cap_ok_reg   <= cap_ok_next;
        old_a_reg    <= old_a_next;
        old_b_reg    <= old_b_next;
        sum_a_reg    <= sum_a_next;
        sum_b_reg    <= sum_b_next;
        new_reg      <= new_next;
        acoef_reg    <= acoef_next;
        ccoef_reg    <= ccoef_next;
        accepted_reg <= accepted_next;
        old_out_reg  <= old_out_next;
        site_out_reg <= site_out_next;
        de_out_reg   <= de_out_next;
    end

    assign response.accepted      = accepted_reg;
    assign response.old_spin      = old_out_reg;
    assign response.site_spin     = site_out_reg;
    assign response.energy_change = de_out_reg;
    assign response.energy_total  = total_reg;
endmodule
